FILE: design/cdq_pkg.sv
// Shared codes, widths and types for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 16;

    // Word action codes
    localparam logic [1:0] ACT_INS_REAR  = 2'd0;
    localparam logic [1:0] ACT_INS_FRONT = 2'd1;
    localparam logic [1:0] ACT_DEL_FRONT = 2'd2;
    localparam logic [1:0] ACT_DEL_REAR  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    // Restriction mode codes; the fourth code allows everything
    localparam logic [1:0] MODE_ALL     = 2'd0;
    localparam logic [1:0] MODE_IN_RES  = 2'd1;
    localparam logic [1:0] MODE_OUT_RES = 2'd2;

    typedef struct packed {
        logic       wr_en;
        logic       rd_en;
        logic [1:0] status;
    } cdq_op_t;

endpackage

`default_nettype wire

FILE: design/cdq_ptr.sv
// Head/tail pointers, empty flag, mode register and per-word decision logic.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ptr
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [1:0]       cfg_wr_data,
    input  wire logic             accept,
    input  wire logic [1:0]       action,
    output cdq_op_t               op,
    output logic      [IDX_W-1:0] wr_addr,
    output logic      [IDX_W-1:0] rd_addr
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [1:0]       mode_reg;

    logic [IDX_W-1:0] tail_inc, tail_dec, head_inc, head_dec;
    logic             full, refused, is_insert, ok;

    always_comb begin
        tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
        tail_dec = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
        head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    end

    assign full      = !empty_reg && (tail_inc == head_reg);
    assign refused   = (mode_reg == MODE_IN_RES  && action == ACT_INS_FRONT) ||
                       (mode_reg == MODE_OUT_RES && action == ACT_DEL_REAR);
    assign is_insert = (action == ACT_INS_REAR) || (action == ACT_INS_FRONT);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        empty_next = empty_reg;
        wr_addr   = '0;
        rd_addr   = (action == ACT_DEL_FRONT) ? head_reg : tail_reg;
        op.status = ST_OK;
        ok        = 1'b0;
        if (refused) begin
            op.status = ST_REFUSED;
        end else if (is_insert) begin
            if (full) begin
                op.status = ST_OVERFLOW;
            end else begin
                ok = 1'b1;
                if (empty_reg) begin
                    // first word always lands in slot zero
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_addr    = '0;
                end else if (action == ACT_INS_REAR) begin
                    tail_next = tail_inc;
                    wr_addr   = tail_inc;
                end else begin
                    head_next = head_dec;
                    wr_addr   = head_dec;
                end
            end
        end else begin
            if (empty_reg) begin
                op.status = ST_UNDERFLOW;
            end else begin
                ok = 1'b1;
                if (head_reg == tail_reg) begin
                    // last word out: return pointers home
                    empty_next = 1'b1;
                    head_next  = '0;
                    tail_next  = '0;
                end else if (action == ACT_DEL_FRONT) begin
                    head_next = head_inc;
                end else begin
                    tail_next = tail_dec;
                end
            end
        end
        op.wr_en = accept && ok && is_insert;
        op.rd_en = accept && ok && !is_insert;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            mode_reg  <= MODE_ALL;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/circular_deque_core.sv
// Top level of the circular deque: entry memory, pointer control, result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------
//  input    | s_valid / s_ready  | s_action, s_data_in
//  result   | m_valid / m_ready  | m_data_out, m_status
//  config   | cfg_wr_en          | cfg_wr_data (restrict mode)
//
// One word per cycle unless stalled; its result shows the cycle after acceptance.
// The pointers update and the memory is written or read at the accept edge;
// the memory read port's registered data feeds the result directly.
// s_ready drops only while a result waits and m_ready is low.
// Reset clears the pointers, empty flag, mode and result valid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic        [1:0]        cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [1:0]        s_action,
    input  wire logic signed [DATA_W-1:0] s_data_in,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed      [DATA_W-1:0] m_data_out,
    output logic             [1:0]        m_status
);

    localparam int IDX_W = $clog2(DEPTH);

    logic              accept;
    cdq_op_t           op;
    logic [IDX_W-1:0]  wr_addr, rd_addr;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              valid_reg;
    logic              hit_reg;
    logic [1:0]        status_reg;

    // hold the input while a result is stalled
    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cdq_ptr #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ptr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .action      (s_action),
        .op          (op),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr)
    );

    always_ff @(posedge aclk) begin
        if (op.wr_en) begin
            mem[wr_addr] <= s_data_in;
        end
        if (op.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= op.status;
            hit_reg    <= op.rd_en;
        end
    end

    assign m_valid    = valid_reg;
    assign m_status   = status_reg;
    assign m_data_out = hit_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

FILE: tb/sv/circular_deque_checker.sv
// Checker for the circular deque: predicts each result word and compares it on the m_ side.
`timescale 1ns / 1ps

module circular_deque_checker
    import cdq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic        [1:0]        cfg_wr_data,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic        [1:0]        s_action,
    input  logic signed [DATA_W-1:0] s_data_in,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [DATA_W-1:0] m_data_out,
    input  logic        [1:0]        m_status,
    output int                       fail_count,
    output int                       pending
);

    localparam int SLOTS = DEPTH_DEF;

    typedef struct {
        logic signed [DATA_W-1:0] data_out;
        logic        [1:0]        status;
    } deque_result_t;

    // Shadow copy of the deque
    logic [DATA_W-1:0] slot_mem [SLOTS];
    int                head_ptr;
    int                tail_ptr;
    logic              dq_empty;
    logic [1:0]        mode_reg;

    deque_result_t     expected_results [$];
    deque_result_t     predicted;
    deque_result_t     oldest;
    int                mismatches;

    initial begin
        fail_count = 0;
        pending    = 0;
        mismatches = 0;
        head_ptr   = 0;
        tail_ptr   = 0;
        dq_empty   = 1'b1;
        mode_reg   = MODE_ALL;
        foreach (slot_mem[i]) slot_mem[i] = '0;
    end

    function automatic deque_result_t deque_predict(input logic [1:0] act,
                                                    input logic [DATA_W-1:0] val);
        deque_result_t r;
        logic          full;
        r.data_out = '0;
        r.status   = ST_OK;
        full = !dq_empty && (((tail_ptr + 1) % SLOTS) == head_ptr);
        // mode check wins over full and empty
        if ((mode_reg == MODE_IN_RES && act == ACT_INS_FRONT) ||
            (mode_reg == MODE_OUT_RES && act == ACT_DEL_REAR)) begin
            r.status = ST_REFUSED;
        end else if (act == ACT_INS_REAR || act == ACT_INS_FRONT) begin
            if (full) begin
                r.status = ST_OVERFLOW;
            end else if (dq_empty) begin
                head_ptr    = 0;
                tail_ptr    = 0;
                slot_mem[0] = val;
                dq_empty    = 1'b0;
            end else if (act == ACT_INS_REAR) begin
                tail_ptr           = (tail_ptr + 1) % SLOTS;
                slot_mem[tail_ptr] = val;
            end else begin
                head_ptr           = (head_ptr + SLOTS - 1) % SLOTS;
                slot_mem[head_ptr] = val;
            end
        end else begin
            if (dq_empty) begin
                r.status = ST_UNDERFLOW;
            end else begin
                r.data_out = slot_mem[(act == ACT_DEL_FRONT) ? head_ptr : tail_ptr];
                if (head_ptr == tail_ptr) begin
                    dq_empty = 1'b1;
                    head_ptr = 0;
                    tail_ptr = 0;
                end else if (act == ACT_DEL_FRONT) begin
                    head_ptr = (head_ptr + 1) % SLOTS;
                end else begin
                    tail_ptr = (tail_ptr + SLOTS - 1) % SLOTS;
                end
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            head_ptr = 0;
            tail_ptr = 0;
            dq_empty = 1'b1;
            mode_reg = MODE_ALL;
            expected_results.delete();
        end else begin
            // retire the result word before predicting a new one
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no prediction pending: data_out %0d status %0d",
                           m_data_out, m_status);
                    mismatches++;
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_data_out !== oldest.data_out) begin
                        $error("data_out mismatch: expected %0d, actual %0d",
                               oldest.data_out, m_data_out);
                        mismatches++;
                    end
                    if (m_status !== oldest.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               oldest.status, m_status);
                        mismatches++;
                    end
                end
            end
            if (cfg_wr_en) mode_reg = cfg_wr_data;
            if (s_valid && s_ready) begin
                predicted = deque_predict(s_action, s_data_in);
                expected_results.push_back(predicted);
            end
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

FILE: tb/sv/circular_deque_core_tb.sv
// Top of the circular deque testbench: clock, reset, stimulus, mode writes and verdict.
`timescale 1ns / 1ps

module circular_deque_core_tb;
    import cdq_pkg::*;

    // fourth mode code behaves like MODE_ALL
    localparam logic [1:0] MODE_ALL_ALT = 2'd3;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PHASE_WORDS  = 134;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic        [1:0]        cfg_wr_data = MODE_ALL;
    logic                     s_valid     = 1'b0;
    logic                     s_ready;
    logic        [1:0]        s_action    = ACT_INS_REAR;
    logic signed [DATA_W-1:0] s_data_in   = '0;
    logic                     m_valid;
    logic                     m_ready     = 1'b0;
    logic signed [DATA_W-1:0] m_data_out;
    logic        [1:0]        m_status;

    int fail_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cycle_count = 0;

    logic [1:0] phase_modes [12] = '{MODE_ALL, MODE_IN_RES, MODE_OUT_RES, MODE_ALL_ALT,
                                     MODE_ALL, MODE_OUT_RES, MODE_IN_RES, MODE_ALL_ALT,
                                     MODE_OUT_RES, MODE_IN_RES, MODE_ALL_ALT, MODE_ALL};

    always #5 aclk = ~aclk;

    circular_deque_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status)
    );

    circular_deque_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_in   (s_data_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // present one word and hold it until accepted; s_valid stays high afterwards
    task automatic push_word(input logic [1:0] act, input logic [DATA_W-1:0] val);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= act;
        s_data_in <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // drop valid and wait until every predicted word has come back
    task automatic drain_words();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        drain_words();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int         ins_pct;
        int         burst_len;
        int         sent;
        logic [1:0] act;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty, single entry, extremes, full, mode refusals
        write_mode(MODE_ALL);
        push_word(ACT_DEL_FRONT, $urandom);
        push_word(ACT_DEL_REAR, $urandom);
        push_word(ACT_INS_REAR, 32'h7FFF_FFFF);
        push_word(ACT_INS_FRONT, 32'h8000_0000);
        push_word(ACT_DEL_FRONT, 32'h0);
        push_word(ACT_DEL_REAR, 32'hFFFF_FFFF);
        push_word(ACT_INS_FRONT, 32'hFFFF_FFFF);
        push_word(ACT_DEL_FRONT, 32'h0);
        for (int k = 0; k < DEPTH_DEF; k++) begin
            push_word((k % 2 == 0) ? ACT_INS_REAR : ACT_INS_FRONT, $urandom);
        end
        push_word(ACT_INS_REAR, 32'h1234_5678);
        push_word(ACT_INS_FRONT, 32'h8765_4321);
        write_mode(MODE_IN_RES);
        push_word(ACT_INS_FRONT, $urandom);
        push_word(ACT_DEL_FRONT, $urandom);
        write_mode(MODE_OUT_RES);
        push_word(ACT_DEL_REAR, $urandom);
        push_word(ACT_INS_FRONT, $urandom);
        push_word(ACT_DEL_FRONT, $urandom);
        write_mode(MODE_ALL_ALT);
        push_word(ACT_INS_FRONT, $urandom);
        push_word(ACT_DEL_REAR, $urandom);

        // random phases: fill-leaning, drain-leaning and balanced bursts
        for (int ph = 0; ph < 12; ph++) begin
            write_mode(phase_modes[ph]);
            if (ph < 4) begin
                tx_idle_pct = 17;
                rx_idle_pct = 86;
            end else if (ph < 8) begin
                tx_idle_pct = 86;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sent = 0;
            while (sent < PHASE_WORDS) begin
                case ($urandom_range(2))
                    0:       ins_pct = 80;
                    1:       ins_pct = 20;
                    default: ins_pct = 50;
                endcase
                burst_len = $urandom_range(4, 40);
                for (int b = 0; b < burst_len && sent < PHASE_WORDS; b++) begin
                    if ($urandom_range(99) < ins_pct)
                        act = $urandom_range(1) ? ACT_INS_REAR : ACT_INS_FRONT;
                    else
                        act = $urandom_range(1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
                    push_word(act, pick_value());
                    sent++;
                end
            end
        end

        drain_words();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
